// ===== hdl/array_mode_finder_assert.svh =====
// assertion helpers for the mode finder controller
`ifndef ARRAY_MODE_FINDER_ASSERT_SVH
`define ARRAY_MODE_FINDER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define AMF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define AMF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/amf_pkg.sv =====
package amf_pkg;

  localparam int unsigned BUFFER_DEPTH = 256;
  localparam int unsigned ADDR_W       = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int unsigned CNT_W        = $clog2(BUFFER_DEPTH + 1);
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned MODE_COUNT_W = 9;

  typedef struct packed {
    logic signed [VALUE_W-1:0] sample_value;
    logic                      is_last;
  } in_word_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0]  mode_value;
    logic [MODE_COUNT_W-1:0]    mode_count;
    logic                       overflowed;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_LATCH,
    S_SCAN,
    S_TALLY,
    S_DONE
  } state_e;

  typedef struct packed {
    logic load;
    logic search_init;
    logic latch;
    logic scan;
    logic tally;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
    logic cand_last;
  } dp_status_t;

endpackage

// ===== hdl/amf_ram.sv =====
module amf_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/amf_datapath.sv =====
module amf_datapath import amf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  in_word_t   item_i,
  output dp_status_t status_o,
  output out_word_t  result_o
);

  localparam logic [CNT_W-1:0] DepthC = CNT_W'(BUFFER_DEPTH);
  localparam logic [CNT_W-1:0] OneC   = CNT_W'(1);

  logic [CNT_W-1:0]   total_q, total_d;
  logic               ovf_q, ovf_d;
  logic [CNT_W-1:0]   i_q, i_d;
  logic [CNT_W-1:0]   j_q, j_d;
  logic [CNT_W-1:0]   hits_q, hits_d;
  logic [CNT_W-1:0]   best_cnt_q, best_cnt_d;
  logic [VALUE_W-1:0] best_val_q, best_val_d;
  logic [VALUE_W-1:0] cand_q, cand_d;

  logic               we;
  logic [ADDR_W-1:0]  raddr;
  logic [VALUE_W-1:0] rdata;
  logic [CNT_W-1:0]   j_next;
  logic [CNT_W-1:0]   total_m1;
  logic               match;

  assign we       = cmd_i.load && (total_q < DepthC);
  assign j_next   = j_q + OneC;
  assign total_m1 = total_q - OneC;
  assign match    = (rdata == cand_q);

  // latch issues element 0, scan runs one address ahead of the compare
  always_comb begin
    if (cmd_i.latch) begin
      raddr = '0;
    end else if (cmd_i.scan) begin
      raddr = j_next[ADDR_W-1:0];
    end else begin
      raddr = i_q[ADDR_W-1:0];
    end
  end

  amf_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (BUFFER_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (total_q[ADDR_W-1:0]),
    .wdata_i (item_i.sample_value),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    total_d    = total_q;
    ovf_d      = ovf_q;
    i_d        = i_q;
    j_d        = j_q;
    hits_d     = hits_q;
    cand_d     = cand_q;
    best_cnt_d = best_cnt_q;
    best_val_d = best_val_q;
    if (cmd_i.load) begin
      if (we) begin
        total_d = total_q + OneC;
      end else begin
        ovf_d = 1'b1;
      end
    end
    if (cmd_i.search_init) begin
      i_d        = '0;
      best_cnt_d = '0;
      best_val_d = '0;
    end
    if (cmd_i.latch) begin
      cand_d = rdata;
      hits_d = '0;
      j_d    = '0;
    end
    if (cmd_i.scan) begin
      hits_d = hits_q + CNT_W'(match);
      j_d    = j_next;
    end
    if (cmd_i.tally) begin
      // strict compare keeps the earliest candidate on a tie
      if (hits_q > best_cnt_q) begin
        best_cnt_d = hits_q;
        best_val_d = cand_q;
      end
      i_d = i_q + OneC;
    end
    if (cmd_i.clear) begin
      total_d = '0;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
      ovf_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
    end else begin
      total_q <= total_d;
      ovf_q   <= ovf_d;
      i_q     <= i_d;
      j_q     <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hits_q     <= hits_d;
    cand_q     <= cand_d;
    best_cnt_q <= best_cnt_d;
    best_val_q <= best_val_d;
  end

  assign status_o.scan_last = (j_q == total_m1);
  assign status_o.cand_last = (i_q == total_m1);

  assign result_o.mode_value = best_val_q;
  assign result_o.mode_count = MODE_COUNT_W'(best_cnt_q);
  assign result_o.overflowed = ovf_q;

endmodule

// ===== hdl/amf_controller.sv =====
module amf_controller import amf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  logic       is_last_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       done_o
);

`include "array_mode_finder_assert.svh"

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i && is_last_i) begin
          state_d = S_FETCH;
        end
      end
      S_FETCH: state_d = S_LATCH;
      S_LATCH: state_d = S_SCAN;
      S_SCAN: begin
        if (status_i.scan_last) begin
          state_d = S_TALLY;
        end
      end
      S_TALLY: begin
        state_d = status_i.cand_last ? S_DONE : S_FETCH;
      end
      S_DONE: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        busy_o            = 1'b0;
        cmd_o.load        = start_i;
        cmd_o.search_init = start_i && is_last_i;
      end
      S_FETCH: begin
      end
      S_LATCH: cmd_o.latch = 1'b1;
      S_SCAN:  cmd_o.scan  = 1'b1;
      S_TALLY: cmd_o.tally = 1'b1;
      S_DONE: begin
        done_o      = 1'b1;
        cmd_o.clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `AMF_ASSERT_NEXT(a_done_single, done_o, !done_o, "result strobe longer than one cycle")
  `AMF_ASSERT_NOW(a_busy_fall, $fell(busy_o), $past(done_o), "busy dropped without a result")
  `AMF_ASSERT_NEXT(a_last_starts, start_i && !busy_o && is_last_i, busy_o,
                   "last word did not start the search")
  `AMF_ASSERT_NEXT(a_load_idle, start_i && !busy_o && !is_last_i, !busy_o,
                   "ordinary word left the block busy")

endmodule

// ===== hdl/array_mode_finder.sv =====
// channel  | handshake          | payload
// ---------+--------------------+-----------------------------------------
// input    | start / busy       | item_i   (sample_value, is_last)
// result   | done_o strobe      | result_o (mode_value, mode_count, overflowed)
//
// a word is taken when start is high and busy is low; words past the store depth are dropped
// a last word starts the search: every candidate goes through fetch, latch,
// a scan of all stored words and tally, as the store has a single read port
// busy is high from the cycle after a last word through the cycle of the result strobe
// reset clears the word count and overflow flag, the store needs no clearing
// the result strobe is high for one cycle only; the receiver cannot stall it
module array_mode_finder import amf_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  in_word_t  item_i,
  output logic      done_o,
  output out_word_t result_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  amf_controller u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .is_last_i (item_i.is_last),
    .status_i  (status),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .done_o    (done_o)
  );

  amf_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .status_o (status),
    .result_o (result_o)
  );

endmodule

// ===== test/array_mode_finder_tb.sv =====
module array_mode_finder_tb;
  import amf_pkg::*;

  localparam int unsigned RANDOM_WORDS = 1500;
  // the limit must cover the search of a full store, during which nothing is accepted
  localparam int unsigned QUIET_LIMIT  = 4 * (BUFFER_DEPTH * (BUFFER_DEPTH + 3) + 1) + 1000;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last;
    logic               typed;
    out_word_t          want;
  } dir_row_t;

  typedef struct {
    in_word_t  word;
    bit        typed;
    out_word_t want;
  } stim_t;

  // hand-picked words; typed rows carry a result read straight off the behaviour
  localparam dir_row_t DIRECTED [24] = '{
    '{32'h7FFFFFFF, 1'b1, 1'b1, '{32'h7FFFFFFF, 9'd1, 1'b0}},
    '{32'h80000000, 1'b1, 1'b1, '{32'h80000000, 9'd1, 1'b0}},
    '{32'h00000000, 1'b1, 1'b1, '{32'h00000000, 9'd1, 1'b0}},
    '{32'hFFFFFFFF, 1'b1, 1'b1, '{32'hFFFFFFFF, 9'd1, 1'b0}},
    '{32'd5,        1'b0, 1'b0, '0},
    '{32'd9,        1'b0, 1'b0, '0},
    '{32'd9,        1'b0, 1'b0, '0},
    '{32'd5,        1'b0, 1'b0, '0},
    '{32'd7,        1'b1, 1'b0, '0},
    '{32'd3,        1'b0, 1'b0, '0},
    '{32'd3,        1'b0, 1'b0, '0},
    '{32'd3,        1'b0, 1'b0, '0},
    '{32'd3,        1'b1, 1'b0, '0},
    '{32'h80000000, 1'b0, 1'b0, '0},
    '{32'h7FFFFFFF, 1'b0, 1'b0, '0},
    '{32'h7FFFFFFF, 1'b0, 1'b0, '0},
    '{32'h80000000, 1'b1, 1'b0, '0},
    '{32'd1,        1'b0, 1'b0, '0},
    '{32'd2,        1'b0, 1'b0, '0},
    '{32'd3,        1'b0, 1'b0, '0},
    '{32'd4,        1'b1, 1'b0, '0},
    '{32'd8,        1'b0, 1'b0, '0},
    '{32'd6,        1'b0, 1'b0, '0},
    '{32'd6,        1'b1, 1'b0, '0}
  };

  logic      clk_i  = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start  = 1'b0;
  logic      busy;
  in_word_t  item_i = '0;
  logic      done_o;
  out_word_t result_o;

  array_mode_finder DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  stim_t       stim_q [$];
  out_word_t   mode_q [$];
  int unsigned word_idx    = 0;
  int unsigned quiet_count = 0;
  int unsigned mismatches  = 0;
  int unsigned modes_seen  = 0;
  int unsigned drops_seen  = 0;
  int unsigned largest_block = 0;

  // own copy of the block's store
  logic [VALUE_W-1:0] sample_store [BUFFER_DEPTH];
  int unsigned        sample_fill = 0;
  bit                 drop_seen   = 1'b0;

  task automatic mode_predict(input in_word_t w, output bit produced, output out_word_t res);
    logic [VALUE_W-1:0] best;
    int unsigned        best_hits;
    int unsigned        hits;
    produced = 1'b0;
    res      = '0;
    if (sample_fill < BUFFER_DEPTH) begin
      sample_store[sample_fill] = w.sample_value;
      sample_fill++;
    end else begin
      drop_seen = 1'b1;
    end
    if (w.is_last) begin
      best      = '0;
      best_hits = 0;
      for (int i = 0; i < sample_fill; i++) begin
        hits = 0;
        for (int j = 0; j < sample_fill; j++)
          if (sample_store[j] == sample_store[i]) hits++;
        // strict compare so the earliest value keeps a tie
        if (hits > best_hits) begin
          best_hits = hits;
          best      = sample_store[i];
        end
      end
      res.mode_value = best;
      res.mode_count = MODE_COUNT_W'(best_hits);
      res.overflowed = drop_seen;
      produced       = 1'b1;
      sample_fill    = 0;
      drop_seen      = 1'b0;
    end
  endtask

  task automatic build_stimulus();
    stim_t              s;
    logic [VALUE_W-1:0] pool [6];
    int unsigned        pool_n;
    int unsigned        len;
    int unsigned        blocks;
    int unsigned        total;
    foreach (DIRECTED[k]) begin
      s.word.sample_value = DIRECTED[k].value;
      s.word.is_last      = DIRECTED[k].last;
      s.typed             = DIRECTED[k].typed;
      s.want              = DIRECTED[k].want;
      stim_q.push_back(s);
    end
    blocks = 0;
    total  = 0;
    while (total < RANDOM_WORDS) begin
      // a few blocks fill the store exactly, drop the last word, or drop many
      if (blocks == 5)       len = BUFFER_DEPTH;
      else if (blocks == 30) len = BUFFER_DEPTH + 1;
      else if (blocks == 60) len = BUFFER_DEPTH + $urandom_range(2, 40);
      else if ($urandom_range(99) < 75) len = $urandom_range(1, 12);
      else len = $urandom_range(13, 48);
      pool_n = $urandom_range(1, 6);
      for (int p = 0; p < 6; p++) begin
        case ($urandom_range(9))
          0: pool[p] = 32'h80000000;
          1: pool[p] = 32'h7FFFFFFF;
          2: pool[p] = 32'h00000000;
          3: pool[p] = 32'hFFFFFFFF;
          4, 5: pool[p] = VALUE_W'($urandom_range(0, 15));
          default: pool[p] = $urandom;
        endcase
      end
      for (int e = 0; e < len; e++) begin
        if ($urandom_range(99) < 80) s.word.sample_value = pool[$urandom_range(pool_n - 1)];
        else s.word.sample_value = $urandom;
        s.word.is_last = (e == len - 1);
        s.typed        = 1'b0;
        s.want         = '0;
        stim_q.push_back(s);
      end
      if (len > largest_block) largest_block = len;
      total += len;
      blocks++;
    end
  endtask

  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t res;
    bit        took;
    bit        produced;
    bit        idle;
    if (rst_ni) begin
      if (done_o) begin
        modes_seen++;
        if (result_o.overflowed === 1'b1) drops_seen++;
        if (mode_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected mode word: value %0d count %0d overflowed %0b",
                     result_o.mode_value, result_o.mode_count, result_o.overflowed);
        end else begin
          want = mode_q.pop_front();
          if (result_o.mode_value !== want.mode_value ||
              result_o.mode_count !== want.mode_count ||
              result_o.overflowed !== want.overflowed) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mode word mismatch: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       want.mode_value, want.mode_count, want.overflowed,
                       result_o.mode_value, result_o.mode_count, result_o.overflowed);
          end
        end
      end

      took = start && !busy;
      if (took) begin
        mode_predict(stim_q[word_idx].word, produced, res);
        if (produced) mode_q.push_back(stim_q[word_idx].typed ? stim_q[word_idx].want : res);
        word_idx++;
      end

      // hold a word that is still waiting, otherwise offer the next or idle
      if (!(start && !took)) begin
        idle = ($urandom_range(99) < 27) && !(word_idx >= 700 && word_idx < 1000);
        if (word_idx < stim_q.size() && !idle) begin
          start  <= 1'b1;
          item_i <= stim_q[word_idx].word;
        end else begin
          start <= 1'b0;
        end
      end

      if (took || done_o) quiet_count = 0;
      else quiet_count++;
      if (quiet_count >= QUIET_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", quiet_count);
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (word_idx == stim_q.size());
    while (mode_q.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    $display("%0d words sent, %0d mode words checked, %0d of them with dropped words",
             word_idx, modes_seen, drops_seen);
    $display("largest block %0d words, %0d mismatches", largest_block, mismatches);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/amf_pkg.sv
hdl/amf_ram.sv
hdl/amf_datapath.sv
hdl/amf_controller.sv
hdl/array_mode_finder.sv
test/array_mode_finder_tb.sv
